/* hdl/ledbc_pkg.sv */
// Shared types, codes and constants of the LED blink controller.
package ledbc_pkg;

  localparam int NUM_LEDS_DEF    = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 2;
  localparam int CMD_W      = 3;
  localparam int PHASE_W    = 2;
  localparam int MODE_W     = 3;
  localparam int PERIOD_W   = 16;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SINGLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALL    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAST   = 3'd4;

  localparam logic [CMD_W-1:0] CMD_FAST = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NEXT = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PREV = 3'd6;

  localparam logic [PHASE_W-1:0] PH_LIT    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DARK   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TOGGLE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_SLOW     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NORMAL   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FAST     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_POLARITY = 2'd3;

  localparam logic [PERIOD_W-1:0] SLOW_RST   = 16'd10;
  localparam logic [PERIOD_W-1:0] NORMAL_RST = 16'd5;
  localparam logic [PERIOD_W-1:0] FAST_RST   = 16'd2;

  typedef struct packed {
    logic [PERIOD_W-1:0] slow;
    logic [PERIOD_W-1:0] norm;
    logic [PERIOD_W-1:0] fast;
  } period_cfg_t;

  typedef struct packed {
    logic               tick;
    logic               set;
    logic               step_next;
    logic               step_prev;
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase;
  } chan_ctl_t;

endpackage

/* hdl/ledbc_if.sv */
// Valid/ready channel interfaces for request and result words.
interface ledbc_in_if;
  import ledbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [IDX_W-1:0]   led_index;
  logic [CMD_W-1:0]   command;
  logic [PHASE_W-1:0] start_phase;

  modport source (output valid, func, led_index, command, start_phase, input ready);
  modport sink (input valid, func, led_index, command, start_phase, output ready);
endinterface

interface ledbc_out_if #(
  parameter int NUM_LEDS = ledbc_pkg::NUM_LEDS_DEF
);
  logic                valid;
  logic                ready;
  logic [NUM_LEDS-1:0] pin_levels;
  logic [NUM_LEDS-1:0] lit_mask;
  logic                bad_request;

  modport source (output valid, pin_levels, lit_mask, bad_request, input ready);
  modport sink (input valid, pin_levels, lit_mask, bad_request, output ready);
endinterface

/* hdl/led_blink_controller_unit.sv */
// Top level of the LED blink controller: input register, channel update, result register.
// A word accepted into the input register moves on to the result register once that register is free or being read.
// Throughput: one word per cycle while out ready holds; in ready follows out ready through the input register.
// All channels update in parallel in the cycle a word leaves the input register.
// Reset (synchronous, active low): channels off and dark, periods 10/5/2, pins active low,
// both pipeline registers empty.
module led_blink_controller_unit #(
  parameter int NUM_LEDS    = ledbc_pkg::NUM_LEDS_DEF,
  parameter int COUNT_WIDTH = ledbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ledbc_in_if.sink                         in_if,
  ledbc_out_if.source                      out_if,
  input  logic                             cfg_we,
  input  logic [ledbc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ledbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ledbc_pkg::*;

  period_cfg_t         periods_r;
  logic                pol_r;

  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [PHASE_W-1:0]  s1_phase_r;

  logic                out_valid_r;
  logic [NUM_LEDS-1:0] pin_r, lit_r;
  logic                bad_r;

  logic                in_acc, adv, ok;
  logic [NUM_LEDS-1:0] lit_nxt;
  chan_ctl_t           ctl [NUM_LEDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periods_r.slow <= SLOW_RST;
      periods_r.norm <= NORMAL_RST;
      periods_r.fast <= FAST_RST;
      pol_r          <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOW:     periods_r.slow <= cfg_wdata[PERIOD_W-1:0];
        REG_NORMAL:   periods_r.norm <= cfg_wdata[PERIOD_W-1:0];
        REG_FAST:     periods_r.fast <= cfg_wdata[PERIOD_W-1:0];
        REG_POLARITY: pol_r          <= cfg_wdata[0];
      endcase
    end
  end

  assign adv         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc || adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_if.func;
      s1_idx_r   <= in_if.led_index;
      s1_cmd_r   <= in_if.command;
      s1_phase_r <= in_if.start_phase;
    end
  end

  always_comb begin
    unique case (s1_func_r)
      FUNC_TICK:   ok = 1'b1;
      FUNC_SINGLE: ok = (int'(s1_idx_r) < NUM_LEDS) && (s1_cmd_r <= CMD_PREV) &&
                        (s1_phase_r <= PH_TOGGLE);
      FUNC_ALL:    ok = (s1_cmd_r <= CMD_FAST);
      default:     ok = 1'b0;
    endcase
  end

  generate
    for (genvar i = 0; i < NUM_LEDS; i++) begin : g_chan
      assign ctl[i].tick      = adv && (s1_func_r == FUNC_TICK);
      assign ctl[i].set       = adv && ok && ((s1_func_r == FUNC_ALL) ||
                                ((s1_func_r == FUNC_SINGLE) && (int'(s1_idx_r) == i)));
      assign ctl[i].step_next = (s1_func_r == FUNC_SINGLE) && (s1_cmd_r == CMD_NEXT);
      assign ctl[i].step_prev = (s1_func_r == FUNC_SINGLE) && (s1_cmd_r == CMD_PREV);
      assign ctl[i].mode      = s1_cmd_r;
      assign ctl[i].phase     = (s1_func_r == FUNC_ALL) ? PH_DARK : s1_phase_r;

      ledbc_chan #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_chan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl[i]),
        .periods(periods_r),
        .lit_nxt(lit_nxt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lit_r <= lit_nxt;
      pin_r <= pol_r ? ~lit_nxt : lit_nxt;
      bad_r <= !ok;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pin_levels  = pin_r;
  assign out_if.lit_mask    = lit_r;
  assign out_if.bad_request = bad_r;

endmodule

/* hdl/ledbc_chan.sv */
// One LED channel: mode, lit flag, reload period and down counter.
module ledbc_chan #(
  parameter int COUNT_WIDTH = ledbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ledbc_pkg::chan_ctl_t   ctl,
  input  ledbc_pkg::period_cfg_t periods,
  output logic                   lit_nxt
);
  import ledbc_pkg::*;

  logic [MODE_W-1:0]      mode_r, mode_nxt, target;
  logic                   lit_r;
  logic [COUNT_WIDTH-1:0] reload_r, reload_nxt, count_r, count_nxt, count_dec, per_cw;
  logic [PERIOD_W-1:0]    per;

  always_comb begin
    priority if (ctl.step_next) begin
      target = (mode_r >= MODE_FAST) ? MODE_OFF : mode_r + 1'b1;
    end else if (ctl.step_prev) begin
      target = (mode_r == MODE_OFF || mode_r > MODE_FAST) ? MODE_FAST : mode_r - 1'b1;
    end else begin
      target = ctl.mode;
    end
  end

  always_comb begin
    unique case (target)
      MODE_SLOW:   per = periods.slow;
      MODE_NORMAL: per = periods.norm;
      default:     per = periods.fast;
    endcase
  end

  generate
    if (COUNT_WIDTH >= PERIOD_W) begin : g_ext
      assign per_cw = {{(COUNT_WIDTH - PERIOD_W){1'b0}}, per};
    end else begin : g_trunc
      assign per_cw = per[COUNT_WIDTH-1:0];
    end
  endgenerate

  assign count_dec = count_r - 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    lit_nxt    = lit_r;
    reload_nxt = reload_r;
    count_nxt  = count_r;
    if (ctl.set) begin
      mode_nxt = target;
      if (target == MODE_OFF || target == MODE_ON) begin
        lit_nxt    = (target == MODE_ON);
        reload_nxt = '0;
        count_nxt  = '0;
      end else begin
        unique case (ctl.phase)
          PH_LIT:  lit_nxt = 1'b1;
          PH_DARK: lit_nxt = 1'b0;
          default: lit_nxt = ~lit_r;
        endcase
        reload_nxt = per_cw;
        count_nxt  = per_cw;
      end
    end else if (ctl.tick && reload_r != '0) begin
      if (count_dec == '0) begin
        lit_nxt   = ~lit_r;
        count_nxt = reload_r;
      end else begin
        count_nxt = count_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      lit_r    <= 1'b0;
      reload_r <= '0;
      count_r  <= '0;
    end else begin
      mode_r   <= mode_nxt;
      lit_r    <= lit_nxt;
      reload_r <= reload_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/ledbc_checker.sv */
// Port-level checks of the LED blink controller result channel, bound to the top level.
module ledbc_checker #(
  parameter int NUM_LEDS = ledbc_pkg::NUM_LEDS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [NUM_LEDS-1:0] pin_levels,
  input logic [NUM_LEDS-1:0] lit_mask,
  input logic                bad_request
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result word dropped");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pin_levels) && $stable(lit_mask) &&
                                $stable(bad_request))
    else $error("stalled result word changed");

  a_polarity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pin_levels == lit_mask) || (pin_levels == ~lit_mask))
    else $error("pin levels disagree with lit mask");

endmodule

bind led_blink_controller_unit ledbc_checker #(
  .NUM_LEDS(NUM_LEDS)
) u_ledbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .pin_levels (out_if.pin_levels),
  .lit_mask   (out_if.lit_mask),
  .bad_request(out_if.bad_request)
);

/* test/led_blink_controller_unit_tb.sv */
// Self-checking bench for the LED blink controller: predicts each result word from a channel model.
module led_blink_controller_unit_tb;
  import ledbc_pkg::*;

  localparam int NUM_LEDS    = NUM_LEDS_DEF;
  localparam int STALL_LIMIT = 4000;

  localparam logic [FUNC_W-1:0]  FUNC_BAD   = 2'd3;
  localparam logic [CMD_W-1:0]   CMD_OFF    = 3'd0;
  localparam logic [CMD_W-1:0]   CMD_ON     = 3'd1;
  localparam logic [CMD_W-1:0]   CMD_SLOW   = 3'd2;
  localparam logic [CMD_W-1:0]   CMD_NORMAL = 3'd3;
  localparam logic [CMD_W-1:0]   CMD_BAD    = 3'd7;
  localparam logic [PHASE_W-1:0] PH_BAD     = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [IDX_W-1:0]   led_index;
    logic [CMD_W-1:0]   command;
    logic [PHASE_W-1:0] start_phase;
  } led_req_t;

  typedef struct packed {
    logic [NUM_LEDS-1:0] pin_levels;
    logic [NUM_LEDS-1:0] lit_mask;
    logic                bad_request;
  } led_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ledbc_in_if                          in_ch ();
  ledbc_out_if #(.NUM_LEDS(NUM_LEDS))  out_ch ();

  led_blink_controller_unit #(
    .NUM_LEDS    (NUM_LEDS),
    .COUNT_WIDTH (COUNT_WIDTH_DEF)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [PERIOD_W-1:0] slow_period   = SLOW_RST;
  logic [PERIOD_W-1:0] normal_period = NORMAL_RST;
  logic [PERIOD_W-1:0] fast_period   = FAST_RST;
  logic                pins_low      = 1'b1;

  logic [MODE_W-1:0]   chan_mode   [NUM_LEDS] = '{default: MODE_OFF};
  logic                chan_lit    [NUM_LEDS] = '{default: 1'b0};
  logic [PERIOD_W-1:0] chan_reload [NUM_LEDS] = '{default: '0};
  logic [PERIOD_W-1:0] chan_count  [NUM_LEDS] = '{default: '0};

  led_word_t pending_led_words[$];
  int        mismatch_count = 0;
  int        idle_run       = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void set_led_mode(int ch, logic [MODE_W-1:0] mode,
                                       logic [PHASE_W-1:0] phase);
    logic [PERIOD_W-1:0] per;
    per = (mode == MODE_SLOW) ? slow_period : (mode == MODE_NORMAL) ? normal_period : fast_period;
    chan_mode[ch] = mode;
    if (mode == MODE_OFF || mode == MODE_ON) begin
      chan_lit[ch]    = (mode == MODE_ON);
      chan_reload[ch] = '0;
      chan_count[ch]  = '0;
    end else begin
      case (phase)
        PH_LIT:  chan_lit[ch] = 1'b1;
        PH_DARK: chan_lit[ch] = 1'b0;
        default: chan_lit[ch] = ~chan_lit[ch];
      endcase
      chan_reload[ch] = per;
      chan_count[ch]  = per;
    end
  endfunction

  function automatic led_word_t predict_led_word(led_req_t r);
    logic                ok;
    logic [MODE_W-1:0]   target;
    logic [MODE_W-1:0]   cur;
    logic [NUM_LEDS-1:0] lit;
    led_word_t           w;
    ok = 1'b1;
    case (r.func)
      FUNC_TICK: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (chan_reload[i] != '0) begin
            chan_count[i] = chan_count[i] - 1'b1;
            if (chan_count[i] == '0) begin
              chan_lit[i]   = ~chan_lit[i];
              chan_count[i] = chan_reload[i];
            end
          end
        end
      end
      FUNC_SINGLE: begin
        if (r.command == CMD_BAD || r.start_phase == PH_BAD ||
            int'(r.led_index) >= NUM_LEDS) begin
          ok = 1'b0;
        end else begin
          cur = chan_mode[r.led_index];
          if (r.command == CMD_NEXT) begin
            target = (cur >= MODE_FAST) ? MODE_OFF : cur + 1'b1;
          end else if (r.command == CMD_PREV) begin
            target = (cur == MODE_OFF || cur > MODE_FAST) ? MODE_FAST : cur - 1'b1;
          end else begin
            target = r.command;
          end
          set_led_mode(int'(r.led_index), target, r.start_phase);
        end
      end
      FUNC_ALL: begin
        if (r.command > CMD_FAST) begin
          ok = 1'b0;
        end else begin
          for (int i = 0; i < NUM_LEDS; i++) set_led_mode(i, r.command, PH_DARK);
        end
      end
      default: ok = 1'b0;
    endcase
    for (int i = 0; i < NUM_LEDS; i++) lit[i] = chan_lit[i];
    w.lit_mask    = lit;
    w.pin_levels  = pins_low ? ~lit : lit;
    w.bad_request = ~ok;
    return w;
  endfunction

  always @(posedge clk) begin : monitor
    led_word_t got;
    led_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pin_levels  = out_ch.pin_levels;
        got.lit_mask    = out_ch.lit_mask;
        got.bad_request = out_ch.bad_request;
        if (pending_led_words.size() == 0) begin
          $error("result word with no expectation: %h", got);
          mismatch_count++;
        end else begin
          want = pending_led_words.pop_front();
          if (got.pin_levels !== want.pin_levels) begin
            $error("pin_levels: expected %h, got %h", want.pin_levels, got.pin_levels);
            mismatch_count++;
          end
          if (got.lit_mask !== want.lit_mask) begin
            $error("lit_mask: expected %h, got %h", want.lit_mask, got.lit_mask);
            mismatch_count++;
          end
          if (got.bad_request !== want.bad_request) begin
            $error("bad_request: expected %h, got %h", want.bad_request, got.bad_request);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOW:     slow_period   = cfg_wdata;
          REG_NORMAL:   normal_period = cfg_wdata;
          REG_FAST:     fast_period   = cfg_wdata;
          REG_POLARITY: pins_low      = cfg_wdata[0];
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_led_words.push_back(predict_led_word({in_ch.func, in_ch.led_index,
                                                      in_ch.command, in_ch.start_phase}));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
      idle_run++;
    else
      idle_run = 0;
    if (idle_run == STALL_LIMIT) begin
      $display("led_blink_controller_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(input led_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= r.func;
    in_ch.led_index   <= r.led_index;
    in_ch.command     <= r.command;
    in_ch.start_phase <= r.start_phase;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_led_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_led_config(input logic [PERIOD_W-1:0] slow_p, normal_p, fast_p,
                                 input logic pol);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [REG_IDX_W-1:0]  regs [4];
    vals = '{slow_p, normal_p, fast_p, {{(CFG_DATA_W-1){1'b0}}, pol}};
    regs = '{REG_SLOW, REG_NORMAL, REG_FAST, REG_POLARITY};
    settle_block();
    foreach (vals[k]) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic led_req_t rand_led_request();
    led_req_t r;
    int       pick;
    pick          = $urandom_range(99);
    r.func        = FUNC_TICK;
    r.led_index   = IDX_W'($urandom_range(3));
    r.command     = CMD_W'($urandom_range(7));
    r.start_phase = PHASE_W'($urandom_range(3));
    if (pick >= 45 && pick < 85) begin
      r.func        = FUNC_SINGLE;
      r.command     = CMD_W'($urandom_range(CMD_PREV));
      r.start_phase = PHASE_W'($urandom_range(PH_TOGGLE));
    end else if (pick >= 85 && pick < 94) begin
      r.func    = FUNC_ALL;
      r.command = CMD_W'($urandom_range(CMD_FAST));
    end else if (pick >= 94) begin
      case ($urandom_range(3))
        0: r.func = FUNC_BAD;
        1: begin
          r.func    = FUNC_SINGLE;
          r.command = CMD_BAD;
        end
        2: begin
          r.func        = FUNC_SINGLE;
          r.command     = CMD_W'($urandom_range(CMD_PREV));
          r.start_phase = PH_BAD;
        end
        default: begin
          r.func    = FUNC_ALL;
          r.command = CMD_W'($urandom_range(CMD_BAD, CMD_NEXT));
        end
      endcase
    end
    return r;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_word(rand_led_request());
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(led_req_t'{FUNC_TICK, 2'd3, CMD_BAD, PH_BAD});
    send_word(led_req_t'{FUNC_SINGLE, 2'd0, CMD_ON, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd3, CMD_ON, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd3, CMD_OFF, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd1, CMD_SLOW, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd2, CMD_NORMAL, PH_DARK});
    send_word(led_req_t'{FUNC_SINGLE, 2'd3, CMD_FAST, PH_TOGGLE});
    repeat (3) send_word(led_req_t'{FUNC_TICK, 2'd0, CMD_OFF, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd0, CMD_NEXT, PH_TOGGLE});
    send_word(led_req_t'{FUNC_SINGLE, 2'd3, CMD_NEXT, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd3, CMD_PREV, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd0, CMD_PREV, PH_DARK});
    send_word(led_req_t'{FUNC_ALL, 2'd3, CMD_OFF, PH_BAD});
    send_word(led_req_t'{FUNC_ALL, 2'd3, CMD_ON, PH_BAD});
    send_word(led_req_t'{FUNC_ALL, 2'd3, CMD_SLOW, PH_LIT});
    send_word(led_req_t'{FUNC_ALL, 2'd0, CMD_NORMAL, PH_TOGGLE});
    send_word(led_req_t'{FUNC_ALL, 2'd1, CMD_FAST, PH_LIT});
    send_word(led_req_t'{FUNC_ALL, 2'd0, CMD_NEXT, PH_LIT});
    send_word(led_req_t'{FUNC_ALL, 2'd0, CMD_PREV, PH_LIT});
    send_word(led_req_t'{FUNC_ALL, 2'd0, CMD_BAD, PH_LIT});
    send_word(led_req_t'{FUNC_BAD, 2'd2, CMD_ON, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd2, CMD_BAD, PH_LIT});
    send_word(led_req_t'{FUNC_SINGLE, 2'd2, CMD_SLOW, PH_BAD});
    send_word(led_req_t'{FUNC_TICK, 2'd0, CMD_OFF, PH_LIT});
    settle_block();
  endtask

  task automatic test_period_settings();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_led_config(16'd1, 16'd1, 16'd1, 1'b0);
    run_random(60);
    load_led_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_random(60);
    // zero periods: blinks keep their phase and never toggle on a tick
    load_led_config(16'd0, 16'd0, 16'd0, 1'b0);
    run_random(60);
    repeat (3) begin
      load_led_config(PERIOD_W'($urandom_range(1, 6)), PERIOD_W'($urandom_range(1, 6)),
                      PERIOD_W'($urandom_range(1, 6)), 1'($urandom_range(1)));
      run_random(60);
    end
    settle_block();
  endtask

  task automatic test_idle_mixes();
    int send_pct [4] = '{0, 73, 0, 31};
    int recv_pct [4] = '{0, 0, 73, 31};
    foreach (send_pct[k]) begin
      load_led_config(PERIOD_W'($urandom_range(1, 12)), PERIOD_W'($urandom_range(1, 12)),
                      PERIOD_W'($urandom_range(1, 12)), 1'($urandom_range(1)));
      send_idle_pct  = send_pct[k];
      recv_stall_pct = recv_pct[k];
      run_random(120);
    end
    settle_block();
  endtask

  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_block();
    @(posedge clk);
    hold_left = 150;
    @(negedge clk);
    run_random(50);
    settle_block();
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 10;
    recv_stall_pct = 20;
    run_random(20);
    settle_block();
    run_random(20);
    settle_block();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = '0;
    in_ch.led_index   = '0;
    in_ch.command     = '0;
    in_ch.start_phase = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_period_settings();
    test_idle_mixes();
    test_output_hold();
    test_drain_pause();
    settle_block();
    if (mismatch_count == 0 && pending_led_words.size() == 0) begin
      $display("led_blink_controller_unit_tb: clean");
    end else begin
      $display("led_blink_controller_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* led_blink_controller_unit.f */
hdl/ledbc_pkg.sv
hdl/ledbc_if.sv
hdl/ledbc_chan.sv
hdl/led_blink_controller_unit.sv
hdl/ledbc_checker.sv
test/led_blink_controller_unit_tb.sv
